// ----- rtl/core/abm_pkg.sv -----
package abm_pkg;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [4:0]  reg_index;
        logic [31:0] write_data;
        logic [4:0]  new_mode;
        logic        save_status;
        logic [3:0]  cond_field;
        logic [15:0] irq_flags;
        logic [15:0] irq_enables;
        logic        master_enable;
    } t_in;

    typedef struct packed {
        logic [31:0] read_data;
        logic        cond_pass;
        logic        irq_taken;
    } t_out;

    // operation codes
    localparam logic [2:0] OP_READ   = 3'd0;
    localparam logic [2:0] OP_WRITE  = 3'd1;
    localparam logic [2:0] OP_MODE   = 3'd2;
    localparam logic [2:0] OP_IRQ    = 3'd3;
    localparam logic [2:0] OP_SWI    = 3'd4;
    localparam logic [2:0] OP_COND   = 3'd5;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam logic [4:0] MODE_USR = 5'h10;
    localparam logic [4:0] MODE_FIQ = 5'h11;
    localparam logic [4:0] MODE_IRQ = 5'h12;
    localparam logic [4:0] MODE_SVC = 5'h13;
    localparam logic [4:0] MODE_ABT = 5'h17;
    localparam logic [4:0] MODE_UND = 5'h1B;
    localparam logic [4:0] MODE_SYS = 5'h1F;

    localparam logic [4:0] IDX_CPSR = 5'd16;
    localparam logic [4:0] IDX_SPSR = 5'd17;

    localparam logic [31:0] RST_SP     = 32'h0300_7F00;
    localparam logic [31:0] RST_PC     = 32'h0800_0000;
    localparam logic [31:0] RST_IRQ_SP = 32'h0300_7FA0;
    localparam logic [31:0] RST_SVC_SP = 32'h0300_7FE0;
    localparam logic [31:0] VEC_IRQ    = 32'h0000_0018;
    localparam logic [31:0] VEC_SWI    = 32'h0000_0008;

    // bank groups: 0 user, 1 fiq, 2 irq, 3 svc, 4 abt, 5 und, 7 none
    localparam logic [2:0] BK_USR  = 3'd0;
    localparam logic [2:0] BK_FIQ  = 3'd1;
    localparam logic [2:0] BK_IRQ  = 3'd2;
    localparam logic [2:0] BK_SVC  = 3'd3;
    localparam logic [2:0] BK_ABT  = 3'd4;
    localparam logic [2:0] BK_UND  = 3'd5;
    localparam logic [2:0] BK_NONE = 3'd7;

    // commands from controller to datapath
    typedef struct packed {
        logic       load;     // capture input item
        logic       exec;     // do the work of the captured item
    } t_cmd;

    function automatic logic [2:0] bank_of(input logic [4:0] m);
        case (m)
            MODE_USR, MODE_SYS: bank_of = BK_USR;
            MODE_FIQ: bank_of = BK_FIQ;
            MODE_IRQ: bank_of = BK_IRQ;
            MODE_SVC: bank_of = BK_SVC;
            MODE_ABT: bank_of = BK_ABT;
            MODE_UND: bank_of = BK_UND;
            default:  bank_of = BK_NONE;
        endcase
    endfunction

endpackage

// ----- rtl/core/abm_ctrl.sv -----
module abm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    output abm_pkg::t_cmd o_cmd
);
    import abm_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state, n_state;

    // one item at a time: capture, execute, present
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_EXEC;
            S_EXEC: n_state = S_OUT;
            S_OUT:  if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = (r_state == S_OUT);
    assign o_cmd.load = (r_state == S_IDLE) && i_valid;
    assign o_cmd.exec = (r_state == S_EXEC);
endmodule

// ----- rtl/core/abm_dp.sv -----
module abm_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  abm_pkg::t_cmd i_cmd,
    input  abm_pkg::t_in  i_data,
    output abm_pkg::t_out o_data
);
    import abm_pkg::*;

    t_in         r_in;
    t_out        r_out;
    logic [31:0] r_regs [16];
    logic [31:0] r_bank [22];
    logic [31:0] r_spsr;
    logic [3:0]  r_nzcv;
    logic        r_t, r_i, r_f;
    logic [4:0]  r_mode;

    logic [31:0] n_regs [16];
    logic [31:0] n_bank [22];
    logic [31:0] n_spsr;
    logic [3:0]  n_nzcv;
    logic        n_t, n_i, n_f;
    logic [4:0]  n_mode;
    t_out        n_out;

    logic [31:0] cpsr;
    assign cpsr = {r_nzcv, 20'd0, r_i, r_f, r_t, r_mode};

    // index of the r13/r14/saved triple of a bank group
    function automatic logic [4:0] tri_base(input logic [2:0] b);
        case (b)
            BK_FIQ: tri_base = 5'd7;
            BK_IRQ: tri_base = 5'd10;
            BK_SVC: tri_base = 5'd13;
            BK_ABT: tri_base = 5'd16;
            BK_UND: tri_base = 5'd19;
            default: tri_base = 5'd0;
        endcase
    endfunction

    // operation execution
    always_comb begin
        logic [4:0]  tgt;
        logic        keep, sw, take;
        logic [2:0]  ob, nb;
        logic [4:0]  obase, nbase;
        logic [31:0] sp, pc;
        logic        tb;
        logic [3:0]  cnd_n;
        n_regs = r_regs;
        n_bank = r_bank;
        n_spsr = r_spsr;
        n_nzcv = r_nzcv;
        n_t    = r_t;
        n_i    = r_i;
        n_f    = r_f;
        n_mode = r_mode;
        n_out  = '0;
        tgt    = r_in.new_mode;
        keep   = r_in.save_status;
        sw     = 1'b0;
        take   = 1'b0;
        pc     = r_regs[15];
        tb     = r_t;
        cnd_n  = r_nzcv;
        ob     = '0;
        nb     = '0;
        obase  = '0;
        nbase  = '0;
        sp     = '0;
        case (r_in.opcode)
            OP_READ: begin
                if (r_in.reg_index < IDX_CPSR) n_out.read_data = r_regs[r_in.reg_index[3:0]];
                else if (r_in.reg_index == IDX_CPSR) n_out.read_data = cpsr;
                else if (r_in.reg_index == IDX_SPSR) n_out.read_data = r_spsr;
            end
            OP_WRITE: begin
                if (r_in.reg_index < IDX_CPSR) n_regs[r_in.reg_index[3:0]] = r_in.write_data;
                else if (r_in.reg_index == IDX_CPSR) begin
                    n_nzcv = r_in.write_data[31:28];
                    n_t = r_in.write_data[5];
                    n_f = r_in.write_data[6];
                    n_i = r_in.write_data[7];
                end else if (r_in.reg_index == IDX_SPSR) n_spsr = r_in.write_data;
            end
            OP_MODE: sw = 1'b1;
            OP_IRQ: begin
                take = (r_in.irq_flags != '0) && r_in.master_enable && !r_i
                       && ((r_in.irq_flags & r_in.irq_enables) != '0);
                sw = take;
                tgt = MODE_IRQ;
                keep = 1'b1;
                n_out.irq_taken = take;
            end
            OP_SWI: begin
                sw = 1'b1;
                tgt = MODE_SVC;
                keep = 1'b1;
            end
            OP_COND: begin
                case (r_in.cond_field)
                    4'd0:  n_out.cond_pass = cnd_n[2];
                    4'd1:  n_out.cond_pass = !cnd_n[2];
                    4'd2:  n_out.cond_pass = cnd_n[1];
                    4'd3:  n_out.cond_pass = !cnd_n[1];
                    4'd4:  n_out.cond_pass = cnd_n[3];
                    4'd5:  n_out.cond_pass = !cnd_n[3];
                    4'd6:  n_out.cond_pass = cnd_n[0];
                    4'd7:  n_out.cond_pass = !cnd_n[0];
                    4'd8:  n_out.cond_pass = cnd_n[1] && !cnd_n[2];
                    4'd9:  n_out.cond_pass = !cnd_n[1] || cnd_n[2];
                    4'd10: n_out.cond_pass = cnd_n[3] == cnd_n[0];
                    4'd11: n_out.cond_pass = cnd_n[3] != cnd_n[0];
                    4'd12: n_out.cond_pass = !cnd_n[2] && (cnd_n[3] == cnd_n[0]);
                    4'd13: n_out.cond_pass = cnd_n[2] || (cnd_n[3] != cnd_n[0]);
                    4'd14: n_out.cond_pass = 1'b1;
                    default: n_out.cond_pass = 1'b0;
                endcase
            end
            default: ;
        endcase

        // mode switch with banking
        if (sw && tgt != r_mode) begin
            ob = bank_of(r_mode);
            nb = bank_of(tgt);
            obase = tri_base(ob);
            nbase = tri_base(nb);
            // save outgoing
            if (ob == BK_USR) begin
                n_bank[0] = n_regs[13];
                n_bank[1] = n_regs[14];
                n_spsr = cpsr;
            end else if (ob != BK_NONE) begin
                if (ob == BK_FIQ) begin
                    for (int k = 0; k < 5; k++) begin
                        n_bank[2 + k] = n_regs[8 + k];
                        n_regs[8 + k] = r_bank[2 + k];
                    end
                end
                n_bank[obase]      = n_regs[13];
                n_bank[obase + 5'd1] = n_regs[14];
                n_bank[obase + 5'd2] = n_spsr;
            end
            sp = n_spsr;
            // load incoming
            if (nb == BK_USR) begin
                n_regs[13] = n_bank[0];
                n_regs[14] = n_bank[1];
                n_nzcv = sp[31:28];
                n_t = sp[5];
                n_f = sp[6];
                n_i = sp[7];
            end else if (nb != BK_NONE) begin
                if (nb == BK_FIQ) begin
                    for (int k = 0; k < 5; k++) begin
                        n_bank[2 + k] = n_regs[8 + k];
                        n_regs[8 + k] = r_bank[2 + k];
                    end
                end else begin
                    n_nzcv = sp[31:28];
                    n_t = sp[5];
                    n_f = sp[6];
                    n_i = sp[7];
                end
                n_regs[13] = n_bank[nbase];
                n_regs[14] = n_bank[nbase + 5'd1];
                n_spsr = keep ? cpsr : n_bank[nbase + 5'd2];
            end
            n_mode = tgt;
        end

        // exception entry fix-up
        if (take) begin
            n_regs[14] = pc + (tb ? 32'd2 : 32'd0);
            n_regs[15] = VEC_IRQ;
            n_t = 1'b0;
            n_i = 1'b1;
        end else if (r_in.opcode == OP_SWI) begin
            n_regs[14] = pc - (tb ? 32'd2 : 32'd4);
            n_regs[15] = VEC_SWI;
            n_t = 1'b0;
            n_i = 1'b1;
        end
    end

    // item capture and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_data;
        if (i_cmd.exec) r_out <= n_out;
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) begin
                r_regs[k] <= (k == 13) ? RST_SP : (k == 15) ? RST_PC : 32'd0;
            end
            for (int k = 0; k < 22; k++) begin
                r_bank[k] <= (k == 10) ? RST_IRQ_SP : (k == 13) ? RST_SVC_SP : 32'd0;
            end
            r_spsr <= '0;
            r_nzcv <= '0;
            r_t    <= 1'b0;
            r_i    <= 1'b0;
            r_f    <= 1'b1;
            r_mode <= MODE_SYS;
        end else if (i_cmd.exec) begin
            r_regs <= n_regs;
            r_bank <= n_bank;
            r_spsr <= n_spsr;
            r_nzcv <= n_nzcv;
            r_t    <= n_t;
            r_i    <= n_i;
            r_f    <= n_f;
            r_mode <= n_mode;
        end
    end

    assign o_data = r_out;
endmodule

// ----- rtl/core/arm_banked_mode_and_exception_unit_core.sv -----
// banked register file and mode control, one operation per item
// sequence: the input is captured, executed into the result register, then presented until taken
// one item at a time, set by the capture/execute/present controller: no new item until the last result is taken
// reset: synchronous active low; registers zero with sp/pc preset, system mode,
// fiq masked, irq and svc stack pointers preset in the bank
module arm_banked_mode_and_exception_unit_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  abm_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output abm_pkg::t_out o_data
);
    import abm_pkg::*;

    t_cmd cmd;

    abm_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_cmd  (cmd)
    );

    abm_dp u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd),
        .i_data (i_data),
        .o_data (o_data)
    );
endmodule

// ----- tb/tb_arm_banked_mode_and_exception_unit_core.sv -----
module tb_arm_banked_mode_and_exception_unit_core;
    timeunit 1ns;
    timeprecision 1ps;
    import abm_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_data;
    logic o_valid;
    logic i_ready;
    t_out o_data;

    arm_banked_mode_and_exception_unit_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    // shadow copy of the register file and mode state
    logic [31:0] sh_regs [16];
    logic [31:0] sh_bank [22];
    logic [31:0] sh_spsr;
    logic [3:0]  sh_nzcv;
    logic        sh_t, sh_i, sh_f;
    logic [4:0]  sh_mode;

    t_in  op_queue [$];
    t_out result_queue [$];
    int   n_errors;
    int   n_cycles;
    bit   stim_done;
    bit   calm;
    logic o_ready_seen;

    localparam int RANDOM_ITEMS = 1200;
    localparam int CYCLE_LIMIT  = 400000;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] pack_cpsr();
        return {sh_nzcv, 20'd0, sh_i, sh_f, sh_t, sh_mode};
    endfunction

    function automatic void unpack_cpsr(input logic [31:0] w);
        sh_nzcv = w[31:28];
        sh_i    = w[7];
        sh_f    = w[6];
        sh_t    = w[5];
    endfunction

    // index of the sp/lr/spsr triple in the bank, 0 when the mode has none
    function automatic int triple_slot(input logic [4:0] m);
        case (m)
            MODE_FIQ: return 7;
            MODE_IRQ: return 10;
            MODE_SVC: return 13;
            MODE_ABT: return 16;
            MODE_UND: return 19;
            default:  return 0;
        endcase
    endfunction

    function automatic void swap_fiq_regs();
        logic [31:0] t;
        for (int k = 0; k < 5; k++) begin
            t = sh_regs[8+k];
            sh_regs[8+k] = sh_bank[2+k];
            sh_bank[2+k] = t;
        end
    endfunction

    function automatic void change_mode(input logic [4:0] m, input logic keep);
        logic [31:0] cpsr;
        int b;
        if (m == sh_mode) return;
        cpsr = pack_cpsr();
        // save outgoing
        if (sh_mode == MODE_USR || sh_mode == MODE_SYS) begin
            sh_bank[0] = sh_regs[13];
            sh_bank[1] = sh_regs[14];
            sh_spsr = cpsr;
        end else begin
            b = triple_slot(sh_mode);
            if (b != 0) begin
                if (sh_mode == MODE_FIQ) swap_fiq_regs();
                sh_bank[b]   = sh_regs[13];
                sh_bank[b+1] = sh_regs[14];
                sh_bank[b+2] = sh_spsr;
            end
        end
        // load incoming
        if (m == MODE_USR || m == MODE_SYS) begin
            sh_regs[13] = sh_bank[0];
            sh_regs[14] = sh_bank[1];
            unpack_cpsr(sh_spsr);
        end else begin
            b = triple_slot(m);
            if (b != 0) begin
                if (m == MODE_FIQ) swap_fiq_regs();
                else unpack_cpsr(sh_spsr);
                sh_regs[13] = sh_bank[b];
                sh_regs[14] = sh_bank[b+1];
                sh_spsr = keep ? cpsr : sh_bank[b+2];
            end
        end
        sh_mode = m;
    endfunction

    function automatic logic cond_met(input logic [3:0] c);
        logic n, z, cy, v;
        {n, z, cy, v} = sh_nzcv;
        case (c)
            4'd0:  return z;
            4'd1:  return !z;
            4'd2:  return cy;
            4'd3:  return !cy;
            4'd4:  return n;
            4'd5:  return !n;
            4'd6:  return v;
            4'd7:  return !v;
            4'd8:  return cy && !z;
            4'd9:  return !cy || z;
            4'd10: return n == v;
            4'd11: return n != v;
            4'd12: return !z && n == v;
            4'd13: return z || n != v;
            4'd14: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void reset_shadow();
        for (int k = 0; k < 16; k++) sh_regs[k] = '0;
        for (int k = 0; k < 22; k++) sh_bank[k] = '0;
        sh_regs[13] = RST_SP;
        sh_regs[15] = RST_PC;
        sh_bank[10] = RST_IRQ_SP;
        sh_bank[13] = RST_SVC_SP;
        sh_spsr = '0;
        sh_nzcv = '0;
        sh_t = 1'b0;
        sh_i = 1'b0;
        sh_f = 1'b1;
        sh_mode = MODE_SYS;
    endfunction

    // apply one operation to the shadow state and return the expected result
    function automatic t_out execute_op(input t_in x);
        t_out r;
        logic [31:0] pc;
        logic t;
        r = '0;
        case (x.opcode)
            OP_READ: begin
                if (x.reg_index < 16) r.read_data = sh_regs[x.reg_index[3:0]];
                else if (x.reg_index == IDX_CPSR) r.read_data = pack_cpsr();
                else if (x.reg_index == IDX_SPSR) r.read_data = sh_spsr;
            end
            OP_WRITE: begin
                if (x.reg_index < 16) sh_regs[x.reg_index[3:0]] = x.write_data;
                else if (x.reg_index == IDX_CPSR) unpack_cpsr(x.write_data);
                else if (x.reg_index == IDX_SPSR) sh_spsr = x.write_data;
            end
            OP_MODE: change_mode(x.new_mode, x.save_status);
            OP_IRQ: begin
                if (x.irq_flags != 0 && x.master_enable && !sh_i
                        && (x.irq_flags & x.irq_enables) != 0) begin
                    pc = sh_regs[15];
                    t = sh_t;
                    change_mode(MODE_IRQ, 1'b1);
                    sh_regs[14] = pc + (t ? 32'd2 : 32'd0);
                    sh_regs[15] = VEC_IRQ;
                    sh_t = 1'b0;
                    sh_i = 1'b1;
                    r.irq_taken = 1'b1;
                end
            end
            OP_SWI: begin
                pc = sh_regs[15];
                t = sh_t;
                change_mode(MODE_SVC, 1'b1);
                sh_regs[14] = pc - (t ? 32'd2 : 32'd4);
                sh_regs[15] = VEC_SWI;
                sh_t = 1'b0;
                sh_i = 1'b1;
            end
            OP_COND: r.cond_pass = cond_met(x.cond_field);
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_in rand_op();
        t_in x;
        logic [4:0] modes [8];
        modes = '{MODE_USR, MODE_FIQ, MODE_IRQ, MODE_SVC, MODE_ABT, MODE_UND,
                  MODE_SYS, 5'h00};
        x.opcode        = 3'($urandom_range(0, 99) < 95 ? $urandom_range(0, 5)
                                                       : $urandom_range(6, 7));
        x.reg_index     = 5'($urandom_range(0, 9) == 0 ? $urandom_range(18, 31)
                                                      : $urandom_range(0, 17));
        x.write_data    = $urandom();
        x.new_mode      = $urandom_range(0, 3) == 0 ? 5'($urandom())
                                                    : modes[$urandom_range(0, 6)];
        x.save_status   = 1'($urandom());
        x.cond_field    = 4'($urandom());
        x.irq_flags     = $urandom_range(0, 4) == 0 ? 16'd0 : 16'($urandom());
        x.irq_enables   = 16'($urandom());
        x.master_enable = $urandom_range(0, 3) != 0;
        // status writes mostly clear the irq mask so interrupts get taken
        if (x.opcode == OP_WRITE && x.reg_index == IDX_CPSR && $urandom_range(0, 1))
            x.write_data[7] = 1'b0;
        return x;
    endfunction

    function automatic t_in make_op(input logic [2:0] op, input logic [4:0] idx,
                                    input logic [31:0] wd, input logic [4:0] m);
        t_in x;
        x = '0;
        x.opcode = op;
        x.reg_index = idx;
        x.write_data = wd;
        x.new_mode = m;
        return x;
    endfunction

    // stimulus
    initial begin
        t_in x;
        calm = 1'b0;
        op_queue.push_back(make_op(OP_READ, 5'd13, '0, '0));
        op_queue.push_back(make_op(OP_READ, IDX_CPSR, '0, '0));
        op_queue.push_back(make_op(OP_WRITE, 5'd8, 32'hFFFF_FFFF, '0));
        op_queue.push_back(make_op(OP_WRITE, IDX_CPSR, 32'hF000_00FF, '0));
        op_queue.push_back(make_op(OP_READ, IDX_CPSR, '0, '0));
        op_queue.push_back(make_op(OP_WRITE, 5'd20, 32'h1234_5678, '0));
        op_queue.push_back(make_op(OP_READ, 5'd31, '0, '0));
        x = make_op(OP_MODE, '0, '0, MODE_FIQ); x.save_status = 1'b1;
        op_queue.push_back(x);
        op_queue.push_back(make_op(OP_READ, 5'd8, '0, '0));
        op_queue.push_back(make_op(OP_MODE, '0, '0, MODE_FIQ));
        op_queue.push_back(make_op(OP_MODE, '0, '0, MODE_SVC));
        op_queue.push_back(make_op(OP_READ, IDX_SPSR, '0, '0));
        op_queue.push_back(make_op(OP_MODE, '0, '0, 5'h05));
        op_queue.push_back(make_op(OP_MODE, '0, '0, MODE_USR));
        op_queue.push_back(make_op(OP_WRITE, IDX_SPSR, 32'hFFFF_FFFF, '0));
        op_queue.push_back(make_op(OP_WRITE, IDX_CPSR, 32'h5000_0020, '0));
        x = make_op(OP_IRQ, '0, '0, '0);
        x.irq_flags = 16'hFFFF; x.irq_enables = 16'h8000; x.master_enable = 1'b1;
        op_queue.push_back(x);
        op_queue.push_back(make_op(OP_READ, 5'd14, '0, '0));
        op_queue.push_back(x);
        op_queue.push_back(make_op(OP_SWI, '0, '0, '0));
        op_queue.push_back(make_op(OP_READ, 5'd14, '0, '0));
        op_queue.push_back(make_op(OP_UNUSED, 5'd31, 32'hFFFF_FFFF, 5'h1F));
        for (int c = 0; c < 16; c++) begin
            x = make_op(OP_COND, '0, '0, '0);
            x.cond_field = 4'(c);
            op_queue.push_back(x);
        end
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS - 150) begin
                wait (op_queue.size() == 0);
                calm = 1'b1;
            end
            op_queue.push_back(rand_op());
        end
        wait (op_queue.size() == 0 && !i_valid);
        stim_done = 1'b1;
    end

    // driver
    int send_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready_seen) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 19) == 0) begin
                send_gap <= $urandom_range(0, 16);
                i_valid <= 1'b0;
            end else if (op_queue.size() > 0) begin
                i_data <= op_queue.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // record accepted inputs at the rising edge
    always @(posedge i_clk) begin
        o_ready_seen <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            result_queue.push_back(execute_op(i_data));
        end
    end

    // receiver stalls
    int stall_len;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_len > 0) begin
            stall_len <= stall_len - 1;
            i_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 19) == 0) begin
            stall_len <= $urandom_range(0, 16);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && o_valid && i_ready) begin
            if (result_queue.size() == 0) begin
                $error("result transfer with nothing expected");
                n_errors++;
            end else begin
                e = result_queue.pop_front();
                if (o_data.read_data !== e.read_data) begin
                    $error("read_data expected %h actual %h", e.read_data,
                           o_data.read_data);
                    n_errors++;
                end
                if (o_data.cond_pass !== e.cond_pass) begin
                    $error("cond_pass expected %b actual %b", e.cond_pass,
                           o_data.cond_pass);
                    n_errors++;
                end
                if (o_data.irq_taken !== e.irq_taken) begin
                    $error("irq_taken expected %b actual %b", e.irq_taken,
                           o_data.irq_taken);
                    n_errors++;
                end
            end
        end
    end

    // reset, end of run and timeout
    initial begin
        n_errors = 0;
        stim_done = 1'b0;
        send_gap = 0;
        stall_len = 0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_data = '0;
        i_rst_n = 1'b0;
        reset_shadow();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && result_queue.size() == 0);
        repeat (10) @(posedge i_clk);
        if (n_errors == 0 && result_queue.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end
    initial n_cycles = 0;

endmodule
